// File: design/round_robin_thread_scheduler_macros.svh
// Assertion macros used by the scheduler datapath.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH
`ifndef SYNTH
// plain property check
`define RRTS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rrts check failed");
// antecedent in this cycle, consequent in the next
`define RRTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rrts check failed");
`else
`define RRTS_ASSERT(lbl, clk, rst, prop)
`define RRTS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: design/rrts_pkg.sv
// Shared types and codes for the round-robin thread scheduler.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package rrts_pkg;

   // transaction field widths
   localparam int OP_W       = 3;
   localparam int TGT_W      = 3;
   localparam int CHAN_W     = 16;
   localparam int GRANT_W    = 3;
   localparam int STAT_W     = 2;
   localparam int WOKEN_W    = 4;
   localparam int SLOT_W     = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   localparam logic [WOKEN_W-1:0] WOKEN_MAX = '1;

   // operation codes
   localparam logic [OP_W-1:0] OP_CREATE     = 3'd0;
   localparam logic [OP_W-1:0] OP_WAIT       = 3'd1;
   localparam logic [OP_W-1:0] OP_EXIT       = 3'd2;
   localparam logic [OP_W-1:0] OP_NOTIFY_ONE = 3'd3;
   localparam logic [OP_W-1:0] OP_NOTIFY_ALL = 3'd4;
   localparam logic [OP_W-1:0] OP_SCHEDULE   = 3'd5;

   // response status codes
   localparam logic [STAT_W-1:0] RSP_OK         = 2'd0;
   localparam logic [STAT_W-1:0] RSP_FULL       = 2'd1;
   localparam logic [STAT_W-1:0] RSP_NONE_READY = 2'd2;
   localparam logic [STAT_W-1:0] RSP_NOT_IN_USE = 2'd3;

   // slot states held in the table; a free slot is one whose valid bit is clear
   localparam logic [SLOT_W-1:0] SLOT_READY = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_SLEEP = 2'd2;
   localparam logic [SLOT_W-1:0] SLOT_DONE  = 2'd3;

   typedef struct packed {
      logic load;   // capture request, init results and scan pointer
      logic rd;     // read table at scan pointer, advance pointer
      logic ev;     // evaluate the slot read last cycle
      logic emit;   // move results into the response register
   } ctl_cmd_type;

   typedef struct packed {
      logic quick;     // request finishes without touching the table
      logic stop;      // current evaluation ends the operation
      logic rsp_free;  // response register can take a new result
   } dp_status_type;

endpackage

// File: design/round_robin_thread_scheduler.sv
// Top level of the round-robin thread scheduler.
// Depends on rrts_pkg, rrts_controller and rrts_datapath.
`timescale 1ns / 1ps

// Usage
//   req channel: one transaction per scheduler operation. req_tuser carries the
//     operation code; req_tdata carries the target slot and the channel tag.
//   rsp channel: exactly one transaction per request, in request order, with
//     the granted slot, a status code and the number of threads woken.
// Timing
//   A request is taken only while the sequencer is idle. Each operation scans
//   slots in the table: wait, exit and an in-range notify-one visit one slot,
//   create stops at the first free slot or after all MAX_THREADS slots,
//   notify-all visits all MAX_THREADS slots, and schedule visits the
//   current slot and then up to MAX_THREADS more. The result reaches
//   rsp_tvalid through a registered hand-off once the output register is free.
//   The slot table is read one entry per cycle, with a registered read.
// Reset
//   Synchronous and active high: every slot becomes free and the current slot
//   is the last one, so the first schedule starts looking at slot zero.
// Backpressure
//   The result sits in an output register; the next request is still accepted
//   and scanned, and only its hand-off waits until rsp_tready takes the old one.

module round_robin_thread_scheduler #(
   parameter int MAX_THREADS  = 8,
   parameter int CHANNEL_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [2:0] target_thread, [18:3] channel, [23:19] zero
   input  logic [rrts_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [2:0] op
   input  logic [rrts_pkg::OP_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [2:0] granted_thread, [4:3] status, [8:5] woken_count, [15:9] zero
   output logic [rrts_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import rrts_pkg::*;

   localparam int RSP_PAD = RSP_DATA_W - GRANT_W - STAT_W - WOKEN_W;

   ctl_cmd_type   cmd;
   dp_status_type st;

   logic [TGT_W-1:0]   req_target;
   logic [CHAN_W-1:0]  req_channel;
   logic [GRANT_W-1:0] rsp_granted;
   logic [STAT_W-1:0]  rsp_status;
   logic [WOKEN_W-1:0] rsp_woken;

   // unpack request payload
   assign req_target  = req_tdata[TGT_W-1:0];
   assign req_channel = req_tdata[TGT_W +: CHAN_W];

   rrts_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .st         (st)
   );

   // slot table and result path
   rrts_datapath #(
      .MAX_THREADS  (MAX_THREADS),
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .st          (st),
      .req_op      (req_tuser),
      .req_target  (req_target),
      .req_channel (req_channel),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_granted (rsp_granted),
      .rsp_status  (rsp_status),
      .rsp_woken   (rsp_woken)
   );

   // pack response payload, lowest field first
   assign rsp_tdata = {{RSP_PAD{1'b0}}, rsp_woken, rsp_status, rsp_granted};

endmodule

// File: design/rrts_controller.sv
// Sequencer for the scheduler: request capture, table scan, response hand-off.
// Depends on rrts_pkg for the command and status structs.
`timescale 1ns / 1ps

module rrts_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output rrts_pkg::ctl_cmd_type  cmd,
   input  rrts_pkg::dp_status_type st
);
   import rrts_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_PRIME  = 2'd1;
   localparam logic [1:0] S_EVAL   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_PRIME;
            end
         end
         S_PRIME: begin
            if (st.quick) begin
               state_in = S_FINISH;
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.ev = 1'b1;
            if (st.stop) begin
               state_in = S_FINISH;
            end else begin
               cmd.rd = 1'b1;
            end
         end
         S_FINISH: begin
            if (st.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/rrts_datapath.sv
// Slot table, scan pointer, result accumulators and response register.
// Depends on rrts_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "round_robin_thread_scheduler_macros.svh"

module rrts_datapath #(
   parameter int MAX_THREADS  = 8,
   parameter int CHANNEL_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rrts_pkg::ctl_cmd_type          cmd,
   output rrts_pkg::dp_status_type        st,
   input  logic [rrts_pkg::OP_W-1:0]      req_op,
   input  logic [rrts_pkg::TGT_W-1:0]     req_target,
   input  logic [rrts_pkg::CHAN_W-1:0]    req_channel,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output logic [rrts_pkg::GRANT_W-1:0]   rsp_granted,
   output logic [rrts_pkg::STAT_W-1:0]    rsp_status,
   output logic [rrts_pkg::WOKEN_W-1:0]   rsp_woken
);
   import rrts_pkg::*;

   localparam int IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int SW = $clog2(MAX_THREADS + 1);
   localparam int CW = (CHANNEL_BITS < CHAN_W) ? CHANNEL_BITS : CHAN_W;
   localparam int MW = SLOT_W + CW;
   localparam logic [IW-1:0] LAST_SLOT  = IW'(MAX_THREADS - 1);
   localparam logic [SW-1:0] LAST_SCAN  = SW'(MAX_THREADS - 1);
   localparam logic [SW-1:0] LAST_SCHED = SW'(MAX_THREADS);

   // slot table: state and channel tag, one entry per slot
   logic [MW-1:0] mem [MAX_THREADS];
   logic [MW-1:0] rd_ff;

   logic [MAX_THREADS-1:0] valid_ff, valid_in;
   logic [IW-1:0]          cur_ff, cur_in;
   logic [IW-1:0]          addr_ff, addr_in;
   logic [IW-1:0]          ev_addr_ff;
   logic [SW-1:0]          step_ff, step_in;
   logic [OP_W-1:0]        op_ff, op_in;
   logic [CW-1:0]          ch_ff, ch_in;
   logic [GRANT_W-1:0]     granted_ff, granted_in;
   logic [STAT_W-1:0]      status_ff, status_in;
   logic [WOKEN_W-1:0]     woken_ff, woken_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [GRANT_W-1:0]     out_granted_ff, out_granted_in;
   logic [STAT_W-1:0]      out_status_ff, out_status_in;
   logic [WOKEN_W-1:0]     out_woken_ff, out_woken_in;

   logic              tgt_in_range;
   logic              e_valid, e_ready, e_match;
   logic [SLOT_W-1:0] e_slot;
   logic [CW-1:0]     e_ch;
   logic              we, set_valid, clr_valid, found, wake, fail, stop;
   logic [MW-1:0]     wdata;

   assign tgt_in_range = (int'(req_target) < MAX_THREADS);

   assign e_valid = valid_ff[ev_addr_ff];
   assign e_slot  = rd_ff[MW-1:CW];
   assign e_ch    = rd_ff[CW-1:0];
   assign e_ready = e_valid && (e_slot == SLOT_READY);
   assign e_match = e_valid && (e_slot == SLOT_SLEEP) && (e_ch == ch_ff);

   // per-slot decision for the operation in flight
   always_comb begin
      we        = 1'b0;
      wdata     = {SLOT_READY, {CW{1'b0}}};
      set_valid = 1'b0;
      clr_valid = 1'b0;
      found     = 1'b0;
      wake      = 1'b0;
      fail      = 1'b0;
      stop      = 1'b1;
      unique case (op_ff)
         OP_CREATE: begin
            found     = !e_valid;
            we        = found;
            set_valid = found;
            stop      = found || (step_ff == LAST_SCAN);
         end
         OP_WAIT: begin
            we    = e_ready;
            wdata = {SLOT_SLEEP, ch_ff};
            fail  = !e_ready;
         end
         OP_EXIT: begin
            we    = e_ready;
            wdata = {SLOT_DONE, e_ch};
            fail  = !e_ready;
         end
         OP_NOTIFY_ONE: begin
            fail = !e_valid;
            wake = e_match;
            we   = e_match;
         end
         OP_NOTIFY_ALL: begin
            wake = e_match;
            we   = e_match;
            stop = (step_ff == LAST_SCAN);
         end
         OP_SCHEDULE: begin
            if (step_ff == '0) begin
               // first look is at the current slot: release it if finished
               clr_valid = e_valid && (e_slot == SLOT_DONE);
               stop      = 1'b0;
            end else begin
               found = e_ready;
               stop  = found || (step_ff == LAST_SCHED);
            end
         end
         default: begin
         end
      endcase
   end

   assign st.quick    = (op_ff > OP_SCHEDULE) ||
                        ((op_ff == OP_NOTIFY_ONE) && (status_ff == RSP_NOT_IN_USE));
   assign st.stop     = stop;
   assign st.rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      valid_in       = valid_ff;
      cur_in         = cur_ff;
      addr_in        = addr_ff;
      step_in        = step_ff;
      op_in          = op_ff;
      ch_in          = ch_ff;
      granted_in     = granted_ff;
      status_in      = status_ff;
      woken_in       = woken_ff;
      rsp_valid_in   = rsp_valid_ff;
      out_granted_in = out_granted_ff;
      out_status_in  = out_status_ff;
      out_woken_in   = out_woken_ff;

      if (cmd.load) begin
         op_in      = req_op;
         ch_in      = req_channel[CW-1:0];
         step_in    = '0;
         granted_in = '0;
         woken_in   = '0;
         priority if (req_op == OP_CREATE) begin
            status_in = RSP_FULL;
         end else if (req_op == OP_SCHEDULE) begin
            status_in = RSP_NONE_READY;
         end else if ((req_op == OP_NOTIFY_ONE) && !tgt_in_range) begin
            status_in = RSP_NOT_IN_USE;
         end else begin
            status_in = RSP_OK;
         end
         priority if ((req_op == OP_CREATE) || (req_op == OP_NOTIFY_ALL)) begin
            addr_in = '0;
         end else if (req_op == OP_NOTIFY_ONE) begin
            addr_in = IW'(req_target);
         end else begin
            addr_in = cur_ff;
         end
      end

      if (cmd.rd) begin
         addr_in = (addr_ff == LAST_SLOT) ? '0 : addr_ff + 1'b1;
      end

      if (cmd.ev) begin
         step_in = step_ff + 1'b1;
         if (set_valid) begin
            valid_in[ev_addr_ff] = 1'b1;
         end
         if (clr_valid) begin
            valid_in[ev_addr_ff] = 1'b0;
         end
         if (found) begin
            granted_in = GRANT_W'(ev_addr_ff);
            status_in  = RSP_OK;
            if (op_ff == OP_SCHEDULE) begin
               cur_in = ev_addr_ff;
            end
         end
         if (fail) begin
            status_in = RSP_NOT_IN_USE;
         end
         if (wake && (woken_ff != WOKEN_MAX)) begin
            woken_in = woken_ff + 1'b1;
         end
      end

      if (cmd.emit) begin
         rsp_valid_in   = 1'b1;
         out_granted_in = granted_ff;
         out_status_in  = status_ff;
         out_woken_in   = woken_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         cur_ff       <= LAST_SLOT;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff        <= addr_in;
      step_ff        <= step_in;
      op_ff          <= op_in;
      ch_ff          <= ch_in;
      granted_ff     <= granted_in;
      status_ff      <= status_in;
      woken_ff       <= woken_in;
      out_granted_ff <= out_granted_in;
      out_status_ff  <= out_status_in;
      out_woken_ff   <= out_woken_in;
   end

   // table port: registered read at the scan pointer, write at the evaluated slot
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_ff      <= mem[addr_ff];
         ev_addr_ff <= addr_ff;
      end
      if (cmd.ev && we) begin
         mem[ev_addr_ff] <= wdata;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_granted = out_granted_ff;
   assign rsp_status  = out_status_ff;
   assign rsp_woken   = out_woken_ff;

   `RRTS_ASSERT(a_cur_in_table, clock, reset, int'(cur_ff) < MAX_THREADS)
   `RRTS_ASSERT(a_emit_needs_room, clock, reset, !cmd.emit || st.rsp_free)
   `RRTS_ASSERT_NEXT(a_grant_is_live, clock, reset, cmd.ev && found && (op_ff == OP_SCHEDULE), valid_ff[cur_ff])

endmodule
